[hw/rtl/q4cs_pkg.sv]
// ----------------------------------------------------------------------------
// q4cs_pkg
// Shared widths, types and constant functions of the quad4 conduction
// stiffness block: shape-derivative coefficients, entry order, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package q4cs_pkg;

  // structure
  localparam int unsigned NUM_LANES = 4;   // one lane per gauss point
  localparam int unsigned NUM_ENT   = 10;  // upper-triangle entries
  localparam int unsigned ENT_W     = 4;

  // front-end widths
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned DN_W      = 24;
  localparam int unsigned NORM_BITS = 23;
  localparam int unsigned WC_W      = 22;
  localparam int unsigned J_W       = 31;
  localparam int unsigned DET_W     = 60;
  localparam int unsigned DM_W      = 59;
  localparam int unsigned P_W       = 32;

  // lane widths
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned TC_W      = 64;
  localparam int unsigned NUM_W     = 64;
  localparam int unsigned MAG_W     = 63;
  localparam int unsigned N_W       = 107;
  localparam int unsigned QB        = 47;
  localparam int unsigned REM_W     = 60;
  localparam int unsigned CON_W     = 49;
  localparam int unsigned SUM_W     = 51;
  localparam int unsigned OUT_W     = 48;

  // lane latency: product, sum, partials, mid, full, compare, divider, sign
  localparam int unsigned LANE_LAT  = QB + 7;

  // register indexes
  localparam logic REG_THICKNESS    = 1'b0;
  localparam logic REG_CONDUCTIVITY = 1'b1;
  localparam logic [CFG_W-1:0] THICKNESS_RST    = 32'd65536;
  localparam logic [CFG_W-1:0] CONDUCTIVITY_RST = 32'd6553600;

  // 4*W in Q.20: one and 1/sqrt(3)
  localparam int W_ONE = 1048576;
  localparam int W_G   = 605396;

  typedef logic signed [P_W-1:0] pval_t;

  typedef struct packed {
    pval_t p0r;
    pval_t p0c;
    pval_t p1r;
    pval_t p1c;
  } pent_t;

  typedef struct packed {
    logic             vld;
    logic [ENT_W-1:0] k;
    logic             degen;
  } meta_t;

  // 4*W coefficient of a gauss point: axis 0 is d/dxi, axis 1 is d/deta
  function automatic logic signed [WC_W-1:0] wcoef(input int lane, input int axis,
                                                   input int idx);
    int e;
    int v;
    if (axis == 0) e = ((lane & 1) != 0) ? W_G : -W_G;
    else           e = ((lane & 2) != 0) ? W_G : -W_G;
    v = 0;
    if (axis == 0) begin
      unique case (idx)
        0:       v = -(W_ONE - e);
        1:       v = W_ONE - e;
        2:       v = W_ONE + e;
        default: v = -(W_ONE + e);
      endcase
    end else begin
      unique case (idx)
        0:       v = -(W_ONE - e);
        1:       v = -(W_ONE + e);
        2:       v = W_ONE + e;
        default: v = W_ONE - e;
      endcase
    end
    return WC_W'(v);
  endfunction

  // row and column of each emitted entry
  function automatic logic [1:0] ent_row(input logic [ENT_W-1:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
      4'd4, 4'd5, 4'd6:       r = 2'd1;
      4'd7, 4'd8:             r = 2'd2;
      default:                r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] ent_col(input logic [ENT_W-1:0] k);
    logic [1:0] c;
    unique case (k)
      4'd0:             c = 2'd0;
      4'd1, 4'd4:       c = 2'd1;
      4'd2, 4'd5, 4'd7: c = 2'd2;
      default:          c = 2'd3;
    endcase
    return c;
  endfunction

  // jacobian entry: two weighted edge differences, rounded by 16 bits
  function automatic logic signed [J_W-1:0] jac_term(
      input logic signed [WC_W-1:0] a, input logic signed [WC_W-1:0] b,
      input logic signed [DN_W-1:0] da, input logic signed [DN_W-1:0] db);
    logic signed [47:0] t;
    t = a * da + b * db + 48'sd32768;
    return t[46:16];
  endfunction

  // determinant of the 2x2 jacobian
  function automatic logic signed [DET_W-1:0] det_of(
      input logic signed [J_W-1:0] a, input logic signed [J_W-1:0] b,
      input logic signed [J_W-1:0] c, input logic signed [J_W-1:0] d);
    logic signed [63:0] t;
    t = a * b - c * d;
    return t[DET_W-1:0];
  endfunction

  // adjugate row times 4W, rounded by 20 bits
  function automatic logic signed [P_W-1:0] prow(
      input logic signed [J_W-1:0] ja, input logic signed [WC_W-1:0] wa,
      input logic signed [J_W-1:0] jb, input logic signed [WC_W-1:0] wb);
    logic signed [55:0] t;
    t = ja * wa - jb * wb + 56'sd524288;
    return t[51:20];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/quad4_conduction_stiffness.sv]
// ----------------------------------------------------------------------------
// quad4_conduction_stiffness
// 4x4 conduction stiffness of a bilinear quad by 2x2 gauss quadrature,
// emitted as ten upper-triangle entries per element.
// ----------------------------------------------------------------------------
// the first entry passes the front pipeline, the entry sequencer, the
//   47-stage divider and other stages of each gauss-point lane, the sum and
//   the output registers; the other nine follow in consecutive cycles
// throughput: the entry sequencer issues one entry per cycle into the four
//   lanes and takes a new element only after the last entry of the one
//   before; up to five elements wait in the front pipeline
// reset: synchronous, active low; clears valid bits and the sequencer and
//   loads thickness 1.0 and conductivity 100.0; results cannot be stalled
`default_nettype none

module quad4_conduction_stiffness import q4cs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_x_corner0,
  input  logic signed [COORD_W-1:0] in_y_corner0,
  input  logic signed [COORD_W-1:0] in_x_corner1,
  input  logic signed [COORD_W-1:0] in_y_corner1,
  input  logic signed [COORD_W-1:0] in_x_corner2,
  input  logic signed [COORD_W-1:0] in_y_corner2,
  input  logic signed [COORD_W-1:0] in_x_corner3,
  input  logic signed [COORD_W-1:0] in_y_corner3,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  output logic                      out_valid,
  output logic [1:0]                out_row,
  output logic [1:0]                out_column,
  output logic signed [OUT_W-1:0]   out_stiffness_value,
  output logic                      out_degenerate,
  output logic                      out_last
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
  localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(NUM_ENT - 1);

  // configuration registers and their product
  logic [CFG_W-1:0] thickness_r, conductivity_r;
  logic [TC_W-1:0]  tc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thickness_r    <= THICKNESS_RST;
      conductivity_r <= CONDUCTIVITY_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_THICKNESS) thickness_r <= cfg_wdata;
      else if (cfg_index == REG_CONDUCTIVITY) conductivity_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    tc_r <= TC_W'(thickness_r) * TC_W'(conductivity_r);
  end

  // front pipeline moves as a whole; it stalls while stage 5 holds an element that the busy sequencer cannot take
  logic seq_act_r;
  logic [ENT_W-1:0] k_r;
  logic seq_take, fe_en, accept;
  logic f1_v_r, f2_v_r, f3_v_r, f4_v_r, f5_v_r;

  assign seq_take = !seq_act_r || (k_r == ENT_LAST);
  assign fe_en    = !f5_v_r || seq_take;
  assign busy     = !fe_en;
  assign accept   = start && fe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
      f5_v_r <= 1'b0;
    end else if (fe_en) begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
      f5_v_r <= f4_v_r;
    end
  end

  // stage 1: edge differences, x then y
  logic signed [DIFF_W-1:0] f1_d_r [8];

  always_ff @(posedge clk) begin
    if (fe_en) begin
      f1_d_r[0] <= DIFF_W'(in_x_corner1) - DIFF_W'(in_x_corner0);
      f1_d_r[1] <= DIFF_W'(in_x_corner2) - DIFF_W'(in_x_corner3);
      f1_d_r[2] <= DIFF_W'(in_x_corner3) - DIFF_W'(in_x_corner0);
      f1_d_r[3] <= DIFF_W'(in_x_corner2) - DIFF_W'(in_x_corner1);
      f1_d_r[4] <= DIFF_W'(in_y_corner1) - DIFF_W'(in_y_corner0);
      f1_d_r[5] <= DIFF_W'(in_y_corner2) - DIFF_W'(in_y_corner3);
      f1_d_r[6] <= DIFF_W'(in_y_corner3) - DIFF_W'(in_y_corner0);
      f1_d_r[7] <= DIFF_W'(in_y_corner2) - DIFF_W'(in_y_corner1);
    end
  end

  // stage 2: bit length of the largest magnitude
  logic [DIFF_W-1:0]        or_mag;
  logic [LEN_W-1:0]         len_nxt;
  logic signed [DIFF_W-1:0] f2_d_r [8];
  logic [LEN_W-1:0]         f2_len_r;

  always_comb begin
    or_mag = '0;
    for (int i = 0; i < 8; i++) begin
      or_mag = or_mag | (f1_d_r[i][DIFF_W-1] ? DIFF_W'(-f1_d_r[i]) : DIFF_W'(f1_d_r[i]));
    end
    len_nxt = '0;
    for (int b = 0; b < DIFF_W; b++) begin
      if (or_mag[b]) len_nxt = LEN_W'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      f2_d_r   <= f1_d_r;
      f2_len_r <= len_nxt;
    end
  end

  // stage 3: common shift that puts the largest magnitude into [2^22, 2^23)
  logic signed [DN_W-1:0] dn_nxt [8];
  logic signed [DN_W-1:0] f3_d_r [8];

  always_comb begin
    logic [DIFF_W-1:0] m;
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] l;
    for (int i = 0; i < 8; i++) begin
      a = '0;
      l = '0;
      m = f2_d_r[i][DIFF_W-1] ? DIFF_W'(-f2_d_r[i]) : DIFF_W'(f2_d_r[i]);
      if (f2_len_r > LEN_W'(NORM_BITS)) begin
        a = m >> (f2_len_r - LEN_W'(NORM_BITS));
        dn_nxt[i] = f2_d_r[i][DIFF_W-1] ? -DN_W'(a) : DN_W'(a);
      end else begin
        l = DIFF_W'(f2_d_r[i]) << (LEN_W'(NORM_BITS) - f2_len_r);
        dn_nxt[i] = l[DN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) f3_d_r <= dn_nxt;
  end

  // stage 4: jacobian of each gauss point (j00, j01, j10, j11)
  logic signed [J_W-1:0] f4_j_r [NUM_LANES][4];

  always_ff @(posedge clk) begin
    if (fe_en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        f4_j_r[l][0] <= jac_term(wcoef(l, 0, 1), wcoef(l, 0, 2), f3_d_r[0], f3_d_r[1]);
        f4_j_r[l][1] <= jac_term(wcoef(l, 0, 1), wcoef(l, 0, 2), f3_d_r[4], f3_d_r[5]);
        f4_j_r[l][2] <= jac_term(wcoef(l, 1, 3), wcoef(l, 1, 2), f3_d_r[2], f3_d_r[3]);
        f4_j_r[l][3] <= jac_term(wcoef(l, 1, 3), wcoef(l, 1, 2), f3_d_r[6], f3_d_r[7]);
      end
    end
  end

  // stage 5: determinant and adjugate times 4W
  logic signed [DET_W-1:0] det_nxt [NUM_LANES];
  logic signed [DET_W-1:0] det_abs [NUM_LANES];
  pval_t                   f5_p0_r [NUM_LANES][4];
  pval_t                   f5_p1_r [NUM_LANES][4];
  logic                    f5_neg_r  [NUM_LANES];
  logic                    f5_zero_r [NUM_LANES];
  logic [DM_W-1:0]         f5_mag_r  [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      det_nxt[l] = det_of(f4_j_r[l][0], f4_j_r[l][3], f4_j_r[l][1], f4_j_r[l][2]);
      det_abs[l] = det_nxt[l][DET_W-1] ? -det_nxt[l] : det_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        f5_neg_r[l]  <= det_nxt[l][DET_W-1];
        f5_zero_r[l] <= (det_nxt[l] == '0);
        f5_mag_r[l]  <= det_abs[l][DM_W-1:0];
        for (int i = 0; i < 4; i++) begin
          f5_p0_r[l][i] <= prow(f4_j_r[l][3], wcoef(l, 0, i), f4_j_r[l][1], wcoef(l, 1, i));
          f5_p1_r[l][i] <= prow(f4_j_r[l][0], wcoef(l, 1, i), f4_j_r[l][2], wcoef(l, 0, i));
        end
      end
    end
  end

  // entry sequencer: ten operand sets per lane in a shift line
  logic seq_load;
  pent_t           ent_r     [NUM_LANES][NUM_ENT];
  logic            hold_neg_r  [NUM_LANES];
  logic            hold_zero_r [NUM_LANES];
  logic [DM_W-1:0] hold_mag_r  [NUM_LANES];
  logic            hold_degen_r;

  assign seq_load = seq_take && f5_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_act_r <= 1'b0;
      k_r       <= '0;
    end else if (seq_take) begin
      seq_act_r <= f5_v_r;
      k_r       <= '0;
    end else begin
      k_r <= k_r + ENT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (seq_load) begin
      hold_degen_r <= f5_zero_r[0] | f5_zero_r[1] | f5_zero_r[2] | f5_zero_r[3];
      for (int l = 0; l < NUM_LANES; l++) begin
        hold_neg_r[l]  <= f5_neg_r[l];
        hold_zero_r[l] <= f5_zero_r[l];
        hold_mag_r[l]  <= f5_mag_r[l];
        for (int k = 0; k < NUM_ENT; k++) begin
          ent_r[l][k].p0r <= f5_p0_r[l][ent_row(ENT_W'(k))];
          ent_r[l][k].p0c <= f5_p0_r[l][ent_col(ENT_W'(k))];
          ent_r[l][k].p1r <= f5_p1_r[l][ent_row(ENT_W'(k))];
          ent_r[l][k].p1c <= f5_p1_r[l][ent_col(ENT_W'(k))];
        end
      end
    end else begin
      for (int l = 0; l < NUM_LANES; l++) begin
        for (int k = 0; k < NUM_ENT - 1; k++) begin
          ent_r[l][k] <= ent_r[l][k+1];
        end
      end
    end
  end

  // gauss-point lanes
  logic signed [CON_W-1:0] contrib [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    q4cs_lane u_lane (
      .clk      (clk),
      .tc       (tc_r),
      .pin      (ent_r[l][0]),
      .det_neg  (hold_neg_r[l]),
      .det_zero (hold_zero_r[l]),
      .det_mag  (hold_mag_r[l]),
      .contrib  (contrib[l])
    );
  end

  // entry tags travel alongside the lanes
  meta_t meta_r [LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) meta_r[i] <= '0;
    end else begin
      meta_r[0] <= '{vld: seq_act_r, k: k_r, degen: hold_degen_r};
      for (int i = 1; i < LANE_LAT; i++) meta_r[i] <= meta_r[i-1];
    end
  end

  // sum of the four gauss points, in two steps
  logic signed [CON_W:0] s1_a_r, s1_b_r;
  meta_t                 s1_meta_r;

  always_ff @(posedge clk) begin
    s1_a_r <= (CON_W+1)'(contrib[0]) + (CON_W+1)'(contrib[1]);
    s1_b_r <= (CON_W+1)'(contrib[2]) + (CON_W+1)'(contrib[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_meta_r <= '0;
    else        s1_meta_r <= meta_r[LANE_LAT-1];
  end

  // zeroing of degenerate elements, saturation and output transaction
  logic signed [SUM_W-1:0] tot;
  logic signed [OUT_W-1:0] val_nxt;
  logic                    out_valid_r;
  logic [1:0]              out_row_r, out_column_r;
  logic signed [OUT_W-1:0] out_val_r;
  logic                    out_degen_r, out_last_r;

  assign tot = SUM_W'(s1_a_r) + SUM_W'(s1_b_r);

  always_comb begin
    if (s1_meta_r.degen)  val_nxt = '0;
    else if (tot > SAT_HI) val_nxt = SAT_HI[OUT_W-1:0];
    else if (tot < SAT_LO) val_nxt = SAT_LO[OUT_W-1:0];
    else                   val_nxt = tot[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= s1_meta_r.vld;
  end

  always_ff @(posedge clk) begin
    out_row_r    <= ent_row(s1_meta_r.k);
    out_column_r <= ent_col(s1_meta_r.k);
    out_val_r    <= val_nxt;
    out_degen_r  <= s1_meta_r.degen;
    out_last_r   <= (s1_meta_r.k == ENT_LAST);
  end

  assign out_valid           = out_valid_r;
  assign out_row             = out_row_r;
  assign out_column          = out_column_r;
  assign out_stiffness_value = out_val_r;
  assign out_degenerate      = out_degen_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/q4cs_lane.sv]
// ----------------------------------------------------------------------------
// q4cs_lane
// One gauss point's contribution to one stiffness entry: B^T B product,
// scaling by thickness*conductivity, pipelined restoring divide by |det|.
// ----------------------------------------------------------------------------
`default_nettype none

module q4cs_lane import q4cs_pkg::*; (
  input  logic                    clk,
  input  logic [TC_W-1:0]         tc,
  input  pent_t                   pin,
  input  logic                    det_neg,
  input  logic                    det_zero,
  input  logic [DM_W-1:0]         det_mag,
  output logic signed [CON_W-1:0] contrib
);

  localparam int unsigned REM1 = REM_W + 1;

  // stage 1: the two products of the entry
  logic signed [NUM_W-1:0] m0_r, m1_r;
  logic                    neg1_r, zero1_r;
  logic [DM_W-1:0]         dm1_r;

  always_ff @(posedge clk) begin
    m0_r    <= pin.p0r * pin.p0c;
    m1_r    <= pin.p1r * pin.p1c;
    neg1_r  <= det_neg;
    zero1_r <= det_zero;
    dm1_r   <= det_mag;
  end

  // stage 2: numerator sign and magnitude
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] num_abs;
  logic [MAG_W-1:0]        mag2_r;
  logic                    neg2_r, zero2_r;
  logic [DM_W-1:0]         dm2_r;

  assign num     = m0_r + m1_r;
  assign num_abs = num[NUM_W-1] ? -num : num;

  always_ff @(posedge clk) begin
    mag2_r  <= num_abs[MAG_W-1:0];
    neg2_r  <= num[NUM_W-1] ^ neg1_r;
    zero2_r <= zero1_r;
    dm2_r   <= dm1_r;
  end

  // stage 3: partial products of tc * |num|
  logic [63:0]     pll3_r, plh3_r, phl3_r, phh3_r;
  logic            neg3_r, zero3_r;
  logic [DM_W-1:0] dm3_r;

  always_ff @(posedge clk) begin
    pll3_r  <= 64'(tc[31:0])  * 64'(mag2_r[31:0]);
    plh3_r  <= 64'(tc[31:0])  * 64'(mag2_r[MAG_W-1:32]);
    phl3_r  <= 64'(tc[63:32]) * 64'(mag2_r[31:0]);
    phh3_r  <= 64'(tc[63:32]) * 64'(mag2_r[MAG_W-1:32]);
    neg3_r  <= neg2_r;
    zero3_r <= zero2_r;
    dm3_r   <= dm2_r;
  end

  // stage 4: middle partial sum
  logic [64:0]     mid4_r;
  logic [63:0]     ll4_r, hh4_r;
  logic            neg4_r, zero4_r;
  logic [DM_W-1:0] dm4_r;

  always_ff @(posedge clk) begin
    mid4_r  <= 65'(plh3_r) + 65'(phl3_r);
    ll4_r   <= pll3_r;
    hh4_r   <= phh3_r;
    neg4_r  <= neg3_r;
    zero4_r <= zero3_r;
    dm4_r   <= dm3_r;
  end

  // stage 5: full product, dropping 20 fraction bits
  logic [127:0]    full;
  logic [N_W-1:0]  n5_r;
  logic            neg5_r, zero5_r;
  logic [DM_W-1:0] dm5_r;

  assign full = 128'(ll4_r) + (128'(mid4_r) << 32) + (128'(hh4_r) << 64);

  always_ff @(posedge clk) begin
    n5_r    <= full[N_W+19:20];
    neg5_r  <= neg4_r;
    zero5_r <= zero4_r;
    dm5_r   <= dm4_r;
  end

  // divider pipeline, index 0 is the overflow check stage
  logic [REM_W-1:0] rem_r  [QB+1];
  logic [QB-1:0]    nq_r   [QB+1];
  logic             neg_r  [QB+1];
  logic             zero_r [QB+1];
  logic             sat_r  [QB+1];
  logic [DM_W-1:0]  dm_r   [QB+1];
  logic [REM_W-1:0] nhi;
  logic             sat6;

  // quotient reaches 2^47 exactly when the upper part is not below the divisor
  assign nhi  = n5_r[N_W-1:QB];
  assign sat6 = nhi >= REM_W'(dm5_r);

  always_ff @(posedge clk) begin
    rem_r[0]  <= sat6 ? '0 : nhi;
    nq_r[0]   <= n5_r[QB-1:0];
    neg_r[0]  <= neg5_r;
    zero_r[0] <= zero5_r;
    sat_r[0]  <= sat6;
    dm_r[0]   <= dm5_r;
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= QB; s++) begin : g_div
    logic [REM1-1:0] r2;
    logic            ge;

    assign r2 = {rem_r[s-1], nq_r[s-1][QB-1]};
    assign ge = r2 >= REM1'(dm_r[s-1]);

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? REM_W'(r2 - REM1'(dm_r[s-1])) : r2[REM_W-1:0];
      nq_r[s]   <= {nq_r[s-1][QB-2:0], ge};
      neg_r[s]  <= neg_r[s-1];
      zero_r[s] <= zero_r[s-1];
      sat_r[s]  <= sat_r[s-1];
      dm_r[s]   <= dm_r[s-1];
    end
  end

  // signed contribution, zero for a degenerate point
  logic [QB:0]              qv;
  logic signed [CON_W-1:0]  contrib_r;

  assign qv = zero_r[QB] ? '0 : (sat_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, nq_r[QB]});

  always_ff @(posedge clk) begin
    contrib_r <= neg_r[QB] ? -CON_W'(qv) : CON_W'(qv);
  end

  assign contrib = contrib_r;

endmodule

`default_nettype wire

[bench/quad4_conduction_stiffness_test.sv]
// ----------------------------------------------------------------------------
// quad4_conduction_stiffness_test
// Drives quad elements into the conduction stiffness block and checks all ten
// upper-triangle entries of each element against a fixed-point predictor,
// over several thickness/conductivity settings and sender idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quad4_conduction_stiffness_test import q4cs_pkg::*; ;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam longint SHAPE_ONE = 1048576;
  localparam longint SHAPE_G = 605396;
  localparam longint VAL_MAX = 64'sd140737488355327;
  localparam longint VAL_MIN = -64'sd140737488355328;

  typedef struct {
    logic signed [31:0] xc[4];
    logic signed [31:0] yc[4];
  } quad_t;

  typedef struct {
    logic [1:0]        row;
    logic [1:0]        column;
    logic [OUT_W-1:0]  value;
    logic              degen;
    logic              last;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_xc[4];
  logic signed [COORD_W-1:0] in_yc[4];
  logic cfg_we = 1'b0;
  logic cfg_index = REG_THICKNESS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [1:0] out_row;
  logic [1:0] out_column;
  logic signed [OUT_W-1:0] out_stiffness_value;
  logic out_degenerate;
  logic out_last;

  quad_t element_q[$];
  entry_t entry_q[$];
  logic [31:0] thick_r = THICKNESS_RST;
  logic [31:0] cond_r = CONDUCTIVITY_RST;
  int idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  logic took = 1'b0;

  initial for (int i = 0; i < 4; i++) begin
    in_xc[i] = '0;
    in_yc[i] = '0;
  end

  quad4_conduction_stiffness uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_corner0(in_xc[0]), .in_y_corner0(in_yc[0]),
    .in_x_corner1(in_xc[1]), .in_y_corner1(in_yc[1]),
    .in_x_corner2(in_xc[2]), .in_y_corner2(in_yc[2]),
    .in_x_corner3(in_xc[3]), .in_y_corner3(in_yc[3]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_row(out_row), .out_column(out_column),
    .out_stiffness_value(out_stiffness_value), .out_degenerate(out_degenerate),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // floor((v + half) / 2^n)
  function automatic longint round_down(input longint v, input int n);
    longint t;
    t = v + (longint'(1) << (n - 1));
    return t >>> n;
  endfunction

  // expected entries of one element
  function automatic void predict_stiffness(input quad_t q);
    int entry_row[10] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    int entry_col[10] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
    longint xs[4], ys[4], dv[8], acc[10];
    longint ex, ee, j00, j01, j10, j11, det, num, v;
    longint w0[4], w1[4], p0[4], p1[4];
    logic [63:0] mx, mg, tc, dm;
    logic [127:0] prod, quo;
    int len, r, c;
    bit degen;
    entry_t e;
    degen = 0;
    mx = 0;
    len = 0;
    tc = {32'b0, thick_r} * {32'b0, cond_r};
    for (int i = 0; i < 4; i++) begin
      xs[i] = q.xc[i];
      ys[i] = q.yc[i];
    end
    dv = '{xs[1] - xs[0], xs[2] - xs[3], xs[3] - xs[0], xs[2] - xs[1],
           ys[1] - ys[0], ys[2] - ys[3], ys[3] - ys[0], ys[2] - ys[1]};
    for (int i = 0; i < 8; i++) begin
      mg = (dv[i] < 0) ? -dv[i] : dv[i];
      if (mg > mx) mx = mg;
    end
    while (len < 64 && (mx >> len) != 0) len++;
    // normalize edge differences to 23 magnitude bits
    for (int i = 0; i < 8; i++) begin
      if (len > 23) begin
        mg = ((dv[i] < 0) ? -dv[i] : dv[i]) >> (len - 23);
        dv[i] = (dv[i] < 0) ? -longint'(mg) : longint'(mg);
      end else if (len > 0) begin
        dv[i] = dv[i] <<< (23 - len);
      end
    end
    for (int i = 0; i < 10; i++) acc[i] = 0;
    // one pass per gauss point
    for (int pt = 0; pt < 4; pt++) begin
      ex = (pt & 2) ? SHAPE_G : -SHAPE_G;
      ee = (pt & 1) ? SHAPE_G : -SHAPE_G;
      w0 = '{-(SHAPE_ONE - ee), SHAPE_ONE - ee, SHAPE_ONE + ee, -(SHAPE_ONE + ee)};
      w1 = '{-(SHAPE_ONE - ex), -(SHAPE_ONE + ex), SHAPE_ONE + ex, SHAPE_ONE - ex};
      j00 = round_down((SHAPE_ONE - ee) * dv[0] + (SHAPE_ONE + ee) * dv[1], 16);
      j01 = round_down((SHAPE_ONE - ee) * dv[4] + (SHAPE_ONE + ee) * dv[5], 16);
      j10 = round_down((SHAPE_ONE - ex) * dv[2] + (SHAPE_ONE + ex) * dv[3], 16);
      j11 = round_down((SHAPE_ONE - ex) * dv[6] + (SHAPE_ONE + ex) * dv[7], 16);
      det = j00 * j11 - j01 * j10;
      if (det == 0) begin
        degen = 1;
        continue;
      end
      dm = (det < 0) ? -det : det;
      for (int i = 0; i < 4; i++) begin
        p0[i] = round_down(j11 * w0[i] - j01 * w1[i], 20);
        p1[i] = round_down(j00 * w1[i] - j10 * w0[i], 20);
      end
      for (int i = 0; i < 10; i++) begin
        r = entry_row[i];
        c = entry_col[i];
        num = p0[r] * p0[c] + p1[r] * p1[c];
        if (num == 0) continue;
        mg = (num < 0) ? -num : num;
        prod = ({64'b0, tc} * {64'b0, mg}) >> 20;
        quo = prod / {64'b0, dm};
        if (quo >= (128'd1 << 47)) quo = 128'd1 << 47;
        acc[i] += ((num < 0) != (det < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
      end
    end
    for (int i = 0; i < 10; i++) begin
      v = degen ? 0 : acc[i];
      if (v > VAL_MAX) v = VAL_MAX;
      if (v < VAL_MIN) v = VAL_MIN;
      e.row = entry_row[i];
      e.column = entry_col[i];
      e.value = v[OUT_W-1:0];
      e.degen = degen;
      e.last = (i == 9);
      entry_q.push_back(e);
    end
  endfunction

  // driver: next element presented at the falling edge
  always @(negedge clk) begin
    quad_t q;
    if (rst_n && (!start || took)) begin
      if (element_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        q = element_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          in_xc[i] <= q.xc[i];
          in_yc[i] <= q.yc[i];
        end
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // accepted transaction and result checking
  always @(posedge clk) begin
    quad_t q;
    entry_t e;
    took <= start && !busy;
    if (rst_n && start && !busy) begin
      for (int i = 0; i < 4; i++) begin
        q.xc[i] = in_xc[i];
        q.yc[i] = in_yc[i];
      end
      predict_stiffness(q);
    end
    if (rst_n && out_valid) begin
      if (entry_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected entry row %0d col %0d", out_row, out_column);
      end else begin
        e = entry_q.pop_front();
        if (out_row !== e.row || out_column !== e.column || out_stiffness_value !== e.value
            || out_degenerate !== e.degen || out_last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp r%0d c%0d v=%0d dg=%0d l=%0d got r%0d c%0d v=%0d dg=%0d l=%0d",
                     e.row, e.column, $signed(e.value), e.degen, e.last, out_row,
                     out_column, out_stiffness_value, out_degenerate, out_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_THICKNESS) thick_r = val;
    else cond_r = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_quad(input int x0, y0, x1, y1, x2, y2, x3, y3);
    quad_t q;
    q.xc = '{x0, x1, x2, x3};
    q.yc = '{y0, y1, y2, y3};
    element_q.push_back(q);
  endtask

  // mostly plausible quads of random size and place, some pure noise
  task automatic add_random(input int count);
    int cx, cy, s;
    quad_t q;
    repeat (count) begin
      if ($urandom_range(99) < 25) begin
        for (int i = 0; i < 4; i++) begin
          q.xc[i] = $urandom;
          q.yc[i] = $urandom;
        end
        element_q.push_back(q);
      end else begin
        cx = $urandom;
        cy = $urandom;
        s = 1 << $urandom_range(0, 29);
        add_quad(cx - s + $urandom_range(0, s / 2), cy - s + $urandom_range(0, s / 2),
                 cx + s - $urandom_range(0, s / 2), cy - s + $urandom_range(0, s / 2),
                 cx + s - $urandom_range(0, s / 2), cy + s - $urandom_range(0, s / 2),
                 cx - s + $urandom_range(0, s / 2), cy + s - $urandom_range(0, s / 2));
      end
    end
  endtask

  task automatic drain;
    while (element_q.size() > 0 || start || entry_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int one;
    logic [31:0] thick_set[6];
    logic [31:0] cond_set[6];
    int idle_set[6];
    one = 65536;
    thick_set = '{THICKNESS_RST, 32'hFFFF_FFFF, 32'd0, 32'd1, $urandom, 32'h0002_8000};
    cond_set = '{CONDUCTIVITY_RST, 32'hFFFF_FFFF, 32'd12345, 32'd1, $urandom, 32'd0};
    idle_set = '{0, 55, 19, 0, 55, 19};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed elements at reset settings
    add_quad(0, 0, one, 0, one, one, 0, one);
    add_quad(0, 0, 0, one, one, one, one, 0);                    // clockwise
    add_quad(5, 5, 5, 5, 5, 5, 5, 5);                            // all corners equal
    add_quad(0, 0, one, 0, 2 * one, 0, 3 * one, 0);              // collapsed to a line
    add_quad(0, 0, one, one, one, one, 0, 0);                    // folded corners
    add_quad(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_quad(0, 0, 1, 0, 1, 1, 0, 1);                            // one lsb square
    add_quad(0, 0, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 1, 0, 1);  // very thin
    add_quad(-one, -one, 3 * one, -2 * one, 2 * one, one, -2 * one, 2 * one);
    add_quad(-1, -1, -1, -1, -1, -1, -1, -1);
    add_quad(0, 0, 4 * one, 0, one, one, 0, one);                // strongly distorted
    add_quad(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();

    // settings sweep, random elements under each
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_THICKNESS, thick_set[ph]);
      write_reg(REG_CONDUCTIVITY, cond_set[ph]);
      idle_pct = idle_set[ph];
      if (ph == 1) begin
        add_quad(0, 0, 1, 0, 1, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF);
        add_quad(0, 0, one, 0, one, one, 0, one);
      end
      add_random(26);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
